@@ rtl/otq_pkg.sv @@
// Shared types and codes for the ordered thread queue.
package otq_pkg;

    localparam int ID_W   = 16;
    localparam int PRI_W  = 8;
    localparam int TIME_W = 32;

    localparam logic [1:0] OP_PUSH_TAIL    = 2'd0;
    localparam logic [1:0] OP_PUSH_ORDERED = 2'd1;
    localparam logic [1:0] OP_POP          = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRI_W-1:0]  pri;
        logic [TIME_W-1:0] tm;
    } thread_rec_t;

    // Control broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic ins_en;
        logic pop_en;
        logic by_time;
        logic tail_mode;
    } cell_ctrl_t;

endpackage

@@ rtl/otq_cell.sv @@
// One storage cell of the queue chain with its local key compare.
module otq_cell
    import otq_pkg::*;
(
    input  logic        clk,
    input  cell_ctrl_t  ctrl,
    input  thread_rec_t new_rec,
    input  thread_rec_t left_rec,
    input  thread_rec_t right_rec,
    input  logic        occ,
    input  logic        at_tail,
    input  logic        found_in,
    output logic        found_out,
    output thread_rec_t rec,
    output thread_rec_t rec_next
);

    thread_rec_t rec_reg;
    logic        le;
    logic        stop;
    logic        take_new;
    logic        take_left;

    // On an ordered push, the new record goes before the first occupied entry whose key is larger.
    assign le        = ctrl.by_time ? (rec_reg.tm <= new_rec.tm) : (rec_reg.pri <= new_rec.pri);
    assign stop      = occ & ~ctrl.tail_mode & ~le;
    assign found_out = found_in | stop;
    assign take_new  = ctrl.ins_en & ~found_in & (stop | at_tail);
    assign take_left = ctrl.ins_en & found_in;

    always_comb
    begin
        if (ctrl.pop_en)
        begin
            rec_next = right_rec;
        end
        else if (take_new)
        begin
            rec_next = new_rec;
        end
        else if (take_left)
        begin
            rec_next = left_rec;
        end
        else
        begin
            rec_next = rec_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

@@ rtl/ordered_thread_queue_top.sv @@
// Top level of the ordered thread queue: cell chain, occupancy and result register.
// A result beat appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle if not stalled; the chain compares and shifts at accept.
// An input beat is taken whenever the result register is empty or being drained.
// Reset (rst_n low, asynchronous) clears the occupancy count and the result valid flag;
// entry storage is not cleared, since only entries below the count are ever read.
module ordered_thread_queue_top
    import otq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic                key_select,
    input  logic [ID_W-1:0]     thread_id,
    input  logic [PRI_W-1:0]    thread_priority,
    input  logic [TIME_W-1:0]   created_time,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [ID_W-1:0]     popped_id,
    output logic [PRI_W-1:0]    popped_priority,
    output logic [TIME_W-1:0]   popped_time,
    output logic [ID_W-1:0]     head_id,
    output logic [CNT_W-1:0]    entry_count,
    output logic                is_empty
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [ID_W-1:0]   popped_id_reg;
    logic [PRI_W-1:0]  popped_priority_reg;
    logic [TIME_W-1:0] popped_time_reg;
    logic [ID_W-1:0]   head_id_reg;
    logic [CNT_W-1:0]  entry_count_reg;
    logic              is_empty_reg;

    logic        accept;
    logic        is_push;
    logic        is_pop;
    logic        full;
    logic        empty;
    logic [1:0]  status_calc;
    cell_ctrl_t  ctrl;
    thread_rec_t new_rec;

    thread_rec_t cell_rec  [QUEUE_DEPTH];
    thread_rec_t cell_next [QUEUE_DEPTH];
    logic        found     [QUEUE_DEPTH+1];

    // The result register parts the two sides: a new beat is taken while the
    // previous result is being handed off.
    assign in_ready = ~out_valid_reg | out_ready;
    assign accept   = in_valid & in_ready;

    assign is_push = (op == OP_PUSH_TAIL) || (op == OP_PUSH_ORDERED);
    assign is_pop  = (op == OP_POP);
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);

    assign ctrl.ins_en    = accept & is_push & ~full;
    assign ctrl.pop_en    = accept & is_pop & ~empty;
    assign ctrl.by_time   = key_select;
    assign ctrl.tail_mode = (op == OP_PUSH_TAIL);

    assign new_rec.id  = thread_id;
    assign new_rec.pri = thread_priority;
    assign new_rec.tm  = created_time;

    // The insertion point ripples down the chain: each cell tells its right
    // neighbor whether the slot has already been claimed to its left.
    assign found[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        thread_rec_t left_rec;
        thread_rec_t right_rec;

        if (i == 0)
        begin : g_first
            assign left_rec = new_rec;
        end
        else
        begin : g_mid_left
            assign left_rec = cell_rec[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_rec = cell_rec[i];
        end
        else
        begin : g_mid_right
            assign right_rec = cell_rec[i+1];
        end

        otq_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .new_rec   (new_rec),
            .left_rec  (left_rec),
            .right_rec (right_rec),
            .occ       (count_reg > CNT_W'(i)),
            .at_tail   (count_reg == CNT_W'(i)),
            .found_in  (found[i]),
            .found_out (found[i+1]),
            .rec       (cell_rec[i]),
            .rec_next  (cell_next[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        status_calc = ST_OK;
        if (is_push && full)
        begin
            status_calc = ST_PUSH_FULL;
        end
        else if (is_pop && empty)
        begin
            status_calc = ST_POP_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The popped entry is captured from the chain before the operation; head and count after it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg          <= status_calc;
            popped_id_reg       <= ctrl.pop_en ? cell_rec[0].id  : '0;
            popped_priority_reg <= ctrl.pop_en ? cell_rec[0].pri : '0;
            popped_time_reg     <= ctrl.pop_en ? cell_rec[0].tm  : '0;
            head_id_reg         <= (count_next != '0) ? cell_next[0].id : '0;
            entry_count_reg     <= count_next;
            is_empty_reg        <= (count_next == '0);
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign popped_id       = popped_id_reg;
    assign popped_priority = popped_priority_reg;
    assign popped_time     = popped_time_reg;
    assign head_id         = head_id_reg;
    assign entry_count     = entry_count_reg;
    assign is_empty        = is_empty_reg;

    // The occupancy never exceeds the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    // A successful pop removes exactly one entry.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop_en |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not decrement occupancy");

    // A successful push adds exactly one entry.
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins_en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not increment occupancy");

    // The reported count follows the occupancy register after an accepted beat.
    a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (entry_count == count_reg) && (is_empty == (count_reg == '0)))
        else $error("result count disagrees with occupancy");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the ordered thread queue: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

module testbench;
    import otq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Op code 3 has no meaning; the block must leave the queue alone and report ok.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Key selector values for an ordered push.
    localparam logic KEY_PRIORITY = 1'b0;
    localparam logic KEY_TIME     = 1'b1;

    // Number of counted random beats, and the length of the receiver's long hold-off.
    localparam int RANDOM_BEATS = 1250;
    localparam int HOLD_CYCLES  = 300;

    // One result beat as the block reports it.
    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   popped_id;
        logic [PRI_W-1:0]  popped_pri;
        logic [TIME_W-1:0] popped_tm;
        logic [ID_W-1:0]   head_id;
        logic [CNT_W-1:0]  count;
        logic              empty;
    } queue_result_t;

    // Keeps a shadow copy of the queue, predicts each result beat and checks it.
    class thread_queue_scoreboard;
        thread_rec_t   shadow[$];
        queue_result_t pending_results[$];
        int            mismatches;
        int            results_seen;

        function new();
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void note_request(logic [1:0] op, logic by_time, thread_rec_t rec);
            queue_result_t r;
            thread_rec_t   head;
            int            pos;
            r = '0;
            r.status = ST_OK;
            case (op)
                OP_PUSH_TAIL, OP_PUSH_ORDERED:
                begin
                    if (shadow.size() >= QUEUE_DEPTH)
                        r.status = ST_PUSH_FULL;
                    else if (op == OP_PUSH_TAIL)
                        shadow.push_back(rec);
                    else
                    begin
                        // Walk past every entry whose key is not greater, so ties keep order.
                        pos = 0;
                        while (pos < shadow.size())
                        begin
                            if (by_time ? (shadow[pos].tm > rec.tm) : (shadow[pos].pri > rec.pri))
                                break;
                            pos++;
                        end
                        shadow.insert(pos, rec);
                    end
                end
                OP_POP:
                begin
                    if (shadow.size() == 0)
                        r.status = ST_POP_EMPTY;
                    else
                    begin
                        head = shadow.pop_front();
                        r.popped_id  = head.id;
                        r.popped_pri = head.pri;
                        r.popped_tm  = head.tm;
                    end
                end
                default: ;
            endcase
            r.count   = CNT_W'(shadow.size());
            r.empty   = (shadow.size() == 0);
            r.head_id = (shadow.size() != 0) ? shadow[0].id : '0;
            pending_results.push_back(r);
        endfunction

        function void check_response(queue_result_t got);
            queue_result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result beat with nothing pending: status=%0d head=%h count=%0d",
                             got.status, got.head_id, got.count);
                return;
            end
            want = pending_results.pop_front();
            if (got.status != want.status || got.popped_id != want.popped_id
                || got.popped_pri != want.popped_pri || got.popped_tm != want.popped_tm
                || got.head_id != want.head_id || got.count != want.count
                || got.empty != want.empty)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: result %0d expected st=%0d pop=%h/%h/%h head=%h cnt=%0d emp=%0d",
                             results_seen, want.status, want.popped_id, want.popped_pri,
                             want.popped_tm, want.head_id, want.count, want.empty);
                    $display("       got      st=%0d pop=%h/%h/%h head=%h cnt=%0d emp=%0d",
                             got.status, got.popped_id, got.popped_pri, got.popped_tm,
                             got.head_id, got.count, got.empty);
                end
            end
        endfunction
    endclass

    // Clock, reset and every block input start at known values.
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        op = OP_PUSH_TAIL;
    logic              key_select = KEY_PRIORITY;
    logic [ID_W-1:0]   thread_id = '0;
    logic [PRI_W-1:0]  thread_priority = '0;
    logic [TIME_W-1:0] created_time = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [1:0]        status;
    logic [ID_W-1:0]   popped_id;
    logic [PRI_W-1:0]  popped_priority;
    logic [TIME_W-1:0] popped_time;
    logic [ID_W-1:0]   head_id;
    logic [CNT_W-1:0]  entry_count;
    logic              is_empty;

    // When set, the sender offers beats back to back with no idle cycles.
    logic tx_steady = 1'b0;

    thread_queue_scoreboard sb = new();

    ordered_thread_queue_top #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .key_select      (key_select),
        .thread_id       (thread_id),
        .thread_priority (thread_priority),
        .created_time    (created_time),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .popped_id       (popped_id),
        .popped_priority (popped_priority),
        .popped_time     (popped_time),
        .head_id         (head_id),
        .entry_count     (entry_count),
        .is_empty        (is_empty)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Both monitors sample at the rising edge. An output beat always belongs to an input
    // beat accepted at an earlier edge, so the order of these two blocks does not matter.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_request(op, key_select, {thread_id, thread_priority, created_time});
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_response({status, popped_id, popped_priority, popped_time,
                               head_id, entry_count, is_empty});
    end

    // Offers one input beat and returns at the falling edge after it is accepted.
    // It is entered at a falling edge. With no gap, valid stays high and only the payload
    // changes, so valid never sees two assignments in one time step.
    task automatic send_beat(logic [1:0] b_op, logic b_key, logic [ID_W-1:0] b_id,
                             logic [PRI_W-1:0] b_pri, logic [TIME_W-1:0] b_tm);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op              = b_op;
        key_select      = b_key;
        thread_id       = b_id;
        thread_priority = b_pri;
        created_time    = b_tm;
        in_valid        = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
    endtask

    // Random keys lean toward a handful of small values so that ties are common on an
    // ordered push, while the wide draws make every bit toggle.
    function automatic logic [PRI_W-1:0] pick_priority();
        if ($urandom_range(0, 1) == 0)
            return PRI_W'($urandom_range(0, 3));
        return PRI_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return TIME_W'($urandom_range(0, 7));
        else if (r < 6)
            return 32'hFFFF_FFF0 + TIME_W'($urandom_range(0, 15));
        return $urandom;
    endfunction

    // Receiver: ready drops for random gaps. Once enough results have come, it holds off
    // for a long stretch while the sender keeps offering, so that the result register fills
    // and the block stalls its input. Runs until $finish.
    initial
    begin
        int gap;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && sb.results_seen >= 150)
            begin
                held = 1'b1;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                // A stretch with the receiver always ready.
                out_ready = 1'b1;
                repeat ($urandom_range(40, 120)) @(negedge clk);
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    out_ready = 1'b0;
                    repeat (gap) @(negedge clk);
                end
                out_ready = 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    end

    // Main stimulus: reset, directed beats, random beats, drain and verdict.
    initial
    begin
        int counted;
        int push_pct;
        int r;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. A pop and an unused op on the empty queue come first.
        send_beat(OP_POP, KEY_PRIORITY, 16'h1234, 8'h12, 32'h1234_5678);
        send_beat(OP_UNUSED, KEY_TIME, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        // Field extremes through tail pushes, then popped back out to empty.
        send_beat(OP_PUSH_TAIL, KEY_TIME, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_beat(OP_PUSH_TAIL, KEY_PRIORITY, 16'h0000, 8'h00, 32'h0000_0000);
        send_beat(OP_POP, KEY_PRIORITY, 16'h0, 8'h0, 32'h0);
        send_beat(OP_POP, KEY_TIME, 16'h0, 8'h0, 32'h0);
        // Ordered by priority: an insert before the head, then a tie that must go after.
        send_beat(OP_PUSH_ORDERED, KEY_PRIORITY, 16'd1, 8'd10, 32'd100);
        send_beat(OP_PUSH_ORDERED, KEY_PRIORITY, 16'd2, 8'd5, 32'd200);
        send_beat(OP_PUSH_ORDERED, KEY_PRIORITY, 16'd3, 8'd10, 32'd300);
        // Ordered by time: the earliest time lands before the head, the latest at the tail.
        send_beat(OP_PUSH_ORDERED, KEY_TIME, 16'd4, 8'd7, 32'd50);
        send_beat(OP_PUSH_ORDERED, KEY_TIME, 16'd5, 8'd7, 32'hFFFF_FFFF);
        // Fill to the depth with tail pushes, then both pushes on a full queue.
        for (int i = 0; i < QUEUE_DEPTH - 5; i++)
            send_beat(OP_PUSH_TAIL, KEY_PRIORITY, 16'(100 + i), 8'(i), 32'(i));
        send_beat(OP_PUSH_TAIL, KEY_PRIORITY, 16'hAAAA, 8'h55, 32'hAAAA_5555);
        send_beat(OP_PUSH_ORDERED, KEY_PRIORITY, 16'h5555, 8'h00, 32'h0);
        send_beat(OP_PUSH_ORDERED, KEY_TIME, 16'h5A5A, 8'hFF, 32'h0);

        // Random part. Every block of beats picks a push share, so the queue swings between
        // full and empty; unused op codes are sprinkled in but not counted.
        counted  = 0;
        push_pct = 50;
        while (counted < RANDOM_BEATS)
        begin
            if (counted % 40 == 0)
            begin
                case ($urandom_range(0, 4))
                    0: push_pct = 90;
                    1: push_pct = 65;
                    2: push_pct = 50;
                    3: push_pct = 35;
                    default: push_pct = 10;
                endcase
                tx_steady = ($urandom_range(0, 4) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 2)
                send_beat(OP_UNUSED, 1'($urandom), 16'($urandom), 8'($urandom), $urandom);
            else
            begin
                if ($urandom_range(0, 99) < push_pct)
                    send_beat(($urandom_range(0, 9) < 3) ? OP_PUSH_TAIL : OP_PUSH_ORDERED,
                              1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                              pick_priority(), pick_time());
                else
                    send_beat(OP_POP, 1'($urandom_range(0, 1)),
                              16'($urandom_range(0, 65535)), pick_priority(), pick_time());
                counted++;
            end
        end
        in_valid = 1'b0;

        // Drain every pending result, then allow a few more cycles for stray beats.
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
